>>> rtl/aabb_collision_table_defines.svh
// ----------------------------------------------------------------------------
// AABB collision table assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AABB_COLLISION_TABLE_DEFINES_SVH
`define AABB_COLLISION_TABLE_DEFINES_SVH

// invariant that holds at every edge out of reset
`define ACT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ACT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/act_pkg.sv
// ----------------------------------------------------------------------------
// AABB collision table package
// Opcodes, result kinds, status codes and fixed field widths.
// ----------------------------------------------------------------------------
package act_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_HIT     = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int ID_W   = 16;
  localparam int SIZE_W = 12;
  localparam int MASK_W = 8;
  localparam int DIR_W  = 5;
  localparam int OUT_W  = 32;

  localparam logic [3:0] TENTH_STEPS = 4'd10;

endpackage

>>> rtl/aabb_collision_table.sv
// ----------------------------------------------------------------------------
// AABB collision table
// Ordered table of boxes with add, remove and collision query.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                  tuser    tlast
//  in_      in   id, pos_x, pos_y, w, h, mask, solid    opcode   -
//  out_     out  status, other_id, collided, solid,     kind     last
//                dir_x, dir_y
//
//  Add/remove: scan the entries in order to find the id; remove then moves
//  each later entry down one place before the acknowledge.
//  Query: scan the entries in order; each hit squares the x then y offset
//  in the shift-add squarer, then runs the shared add/compare unit per axis.
//  Not ready while an item is in progress. Reset empties the table at once.
//  A stalled output holds the sequencer until the result is taken.
// ----------------------------------------------------------------------------
`include "aabb_collision_table_defines.svh"

module aabb_collision_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int COORD_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // id, pos_x, pos_y, box_width, box_height, channel_mask, solid_flag
  input  logic [((49 + 2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic [1:0]          in_tuser,   // opcode
  output logic                out_tvalid,
  input  logic                out_tready,
  // status, other_id, collided, other_solid, dir_x_tenths, dir_y_tenths
  output logic [act_pkg::OUT_W-1:0] out_tdata,
  output logic [1:0]          out_tuser,  // result_kind
  output logic                out_tlast
);

  localparam int CW   = COORD_WIDTH;
  localparam int IDXW = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int EW   = ((CW > act_pkg::SIZE_W) ? CW : act_pkg::SIZE_W) + 2;
  localparam int DW   = EW + 1;
  localparam int MW   = EW;
  localparam int SW   = 2 * MW;
  localparam int AW   = SW + 10;
  localparam int MCW  = $clog2(MW + 1);
  localparam int OX   = act_pkg::ID_W;
  localparam int OY   = OX + CW;
  localparam int OWD  = OY + CW;
  localparam int OHT  = OWD + act_pkg::SIZE_W;
  localparam int OMK  = OHT + act_pkg::SIZE_W;
  localparam int OSL  = OMK + act_pkg::MASK_W;

  typedef struct packed {
    logic [act_pkg::ID_W-1:0]   id;
    logic [CW-1:0]              x;
    logic [CW-1:0]              y;
    logic [act_pkg::SIZE_W-1:0] w;
    logic [act_pkg::SIZE_W-1:0] h;
    logic [act_pkg::MASK_W-1:0] ch;
    logic                       solid;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_SHIFT, S_ACK, S_SCAN, S_SQ, S_TEN, S_HIT, S_SUM
  } state_t;

  entry_t tbl_r [TABLE_DEPTH];

  state_t                     state_r, state_nxt;
  logic [CNTW-1:0]            cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [1:0]                 op_r, op_nxt, status_r, status_nxt;
  entry_t                     q_r, q_nxt;
  logic                       hit_r, hit_nxt, lsolid_r, lsolid_nxt;
  logic [act_pkg::ID_W-1:0]   lid_r, lid_nxt;
  logic [act_pkg::DIR_W-1:0]  ldx_r, ldx_nxt, ldy_r, ldy_nxt;
  logic signed [DW-1:0]       vx_r, vx_nxt, vy_r, vy_nxt;
  logic [SW-1:0]              mcand_r, mcand_nxt, prod_r, prod_nxt;
  logic [MW-1:0]              mplier_r, mplier_nxt;
  logic [MCW-1:0]             mcnt_r, mcnt_nxt;
  logic [SW-1:0]              ax_r, ax_nxt, ay_r, ay_nxt;
  logic [SW:0]                s_r, s_nxt;
  logic                       sel_y_r, sel_y_nxt;
  logic [AW-1:0]              acc_r, acc_nxt, d_r, d_nxt, rr_r, rr_nxt;
  logic [3:0]                 k_r, k_nxt, t_r, t_nxt;
  logic                       out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [1:0]                 out_kind_r, out_kind_nxt;
  logic [act_pkg::OUT_W-1:0]  out_data_r, out_data_nxt;

  logic                       wr_en;
  logic [IDXW-1:0]            wr_idx, rd_idx;
  entry_t                     wr_data, rd_e;
  logic                       can_load, step_le;
  logic signed [EW-1:0]       qr, qb, qcx, qcy, el, et, er, eb, ecx, ecy;
  logic [3:0]                 t_fin;
  logic signed [DW-1:0]       vsel;
  logic [act_pkg::DIR_W-1:0]  dir;
  logic [SW-1:0]              sq_res;
  logic [MW-1:0]              mag_y;
  logic [AW-1:0]              s_ext;

  function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] n;
    n = -v;
    return v[DW-1] ? n[MW-1:0] : v[MW-1:0];
  endfunction

  function automatic logic [AW-1:0] times400(input logic [SW-1:0] a);
    logic [AW-1:0] e;
    e = AW'(a);
    return (e << 8) + (e << 7) + (e << 4);
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign can_load   = !out_valid_r || out_tready;

  assign rd_idx = (state_r == S_SHIFT) ? idx_r[IDXW-1:0] + IDXW'(1) : idx_r[IDXW-1:0];
  assign rd_e   = tbl_r[rd_idx];

  assign qr  = EW'(signed'(q_r.x)) + EW'({1'b0, q_r.w});
  assign qb  = EW'(signed'(q_r.y)) + EW'({1'b0, q_r.h});
  assign qcx = EW'(signed'(q_r.x)) + EW'({1'b0, q_r.w[act_pkg::SIZE_W-1:1]});
  assign qcy = EW'(signed'(q_r.y)) + EW'({1'b0, q_r.h[act_pkg::SIZE_W-1:1]});
  assign el  = EW'(signed'(rd_e.x));
  assign et  = EW'(signed'(rd_e.y));
  assign er  = el + EW'({1'b0, rd_e.w});
  assign eb  = et + EW'({1'b0, rd_e.h});
  assign ecx = el + EW'({1'b0, rd_e.w[act_pkg::SIZE_W-1:1]});
  assign ecy = et + EW'({1'b0, rd_e.h[act_pkg::SIZE_W-1:1]});

  assign step_le = (acc_r <= rr_r);
  assign t_fin   = t_r + {3'b0, step_le};
  assign vsel    = sel_y_r ? vy_r : vx_r;
  assign dir     = (vsel == '0) ? '0 :
                   (vsel[DW-1] ? -{1'b0, t_fin} : {1'b0, t_fin});
  assign sq_res  = mplier_r[0] ? prod_r + mcand_r : prod_r;
  assign mag_y   = mag(vy_r);
  assign s_ext   = AW'(s_r);

  always_comb begin
    state_nxt = state_r;   cnt_nxt = cnt_r;       idx_nxt = idx_r;
    op_nxt = op_r;         status_nxt = status_r; q_nxt = q_r;
    hit_nxt = hit_r;       lsolid_nxt = lsolid_r; lid_nxt = lid_r;
    ldx_nxt = ldx_r;       ldy_nxt = ldy_r;       vx_nxt = vx_r;
    vy_nxt = vy_r;         mcand_nxt = mcand_r;   prod_nxt = prod_r;
    mplier_nxt = mplier_r; mcnt_nxt = mcnt_r;     ax_nxt = ax_r;
    ay_nxt = ay_r;         s_nxt = s_r;           sel_y_nxt = sel_y_r;
    acc_nxt = acc_r;       d_nxt = d_r;           rr_nxt = rr_r;
    k_nxt = k_r;           t_nxt = t_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt = out_kind_r; out_data_nxt = out_data_r; out_last_nxt = out_last_r;
    wr_en = 1'b0; wr_idx = idx_r[IDXW-1:0]; wr_data = rd_e;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_tuser;
          q_nxt    = '{id: in_tdata[OX-1:0], x: in_tdata[OY-1:OX], y: in_tdata[OWD-1:OY],
                       w: in_tdata[OHT-1:OWD], h: in_tdata[OMK-1:OHT],
                       ch: in_tdata[OSL-1:OMK], solid: in_tdata[OSL]};
          idx_nxt  = '0;
          hit_nxt  = 1'b0; lid_nxt = '0; lsolid_nxt = 1'b0; ldx_nxt = '0; ldy_nxt = '0;
          case (in_tuser)
            act_pkg::OP_ADD, act_pkg::OP_REMOVE: state_nxt = S_FIND;
            act_pkg::OP_QUERY:                   state_nxt = S_SCAN;
            default:                             state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_ACK;
          if (op_r == act_pkg::OP_REMOVE) begin
            status_nxt = act_pkg::ST_NOTFOUND;
          end else if (cnt_r == CNTW'(TABLE_DEPTH)) begin
            status_nxt = act_pkg::ST_FULL;
          end else begin
            status_nxt = act_pkg::ST_OK;
            wr_en = 1'b1; wr_idx = cnt_r[IDXW-1:0]; wr_data = q_r;
            cnt_nxt = cnt_r + CNTW'(1);
          end
        end else if (rd_e.id == q_r.id) begin
          if (op_r == act_pkg::OP_REMOVE) begin
            state_nxt = S_SHIFT;
          end else begin
            status_nxt = act_pkg::ST_PRESENT;
            state_nxt  = S_ACK;
          end
        end else begin
          idx_nxt = idx_r + CNTW'(1);
        end
      end
      S_SHIFT: begin
        if (idx_r + CNTW'(1) < cnt_r) begin
          wr_en = 1'b1; wr_data = rd_e;
          idx_nxt = idx_r + CNTW'(1);
        end else begin
          cnt_nxt = cnt_r - CNTW'(1);
          status_nxt = act_pkg::ST_OK;
          state_nxt = S_ACK;
        end
      end
      S_ACK: begin
        if (can_load) begin
          out_valid_nxt = 1'b1; out_kind_nxt = act_pkg::KIND_ACK; out_last_nxt = 1'b1;
          out_data_nxt = act_pkg::OUT_W'(status_r);
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_SUM;
        end else if (rd_e.id == q_r.id || q_r.ch == '0 || (q_r.ch & rd_e.ch) == '0 ||
                     !(EW'(signed'(q_r.x)) < er && qr > el &&
                       EW'(signed'(q_r.y)) < eb && qb > et)) begin
          idx_nxt = idx_r + CNTW'(1);
        end else begin
          hit_nxt = 1'b1; lid_nxt = rd_e.id; lsolid_nxt = rd_e.solid;
          vx_nxt = DW'(ecx) - DW'(qcx);
          vy_nxt = DW'(ecy) - DW'(qcy);
          mcand_nxt = SW'(mag(DW'(ecx) - DW'(qcx)));
          mplier_nxt = mag(DW'(ecx) - DW'(qcx));
          prod_nxt = '0; mcnt_nxt = '0; sel_y_nxt = 1'b0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        prod_nxt = sq_res; mcand_nxt = mcand_r << 1; mplier_nxt = mplier_r >> 1;
        mcnt_nxt = mcnt_r + MCW'(1);
        if (mcnt_r == MCW'(MW - 1)) begin
          prod_nxt = '0; mcnt_nxt = '0;
          if (!sel_y_r) begin
            ax_nxt = sq_res; sel_y_nxt = 1'b1;
            mcand_nxt = SW'(mag_y); mplier_nxt = mag_y;
          end else begin
            ay_nxt = sq_res; sel_y_nxt = 1'b0;
            s_nxt = {1'b0, ax_r} + {1'b0, sq_res};
            acc_nxt = AW'({1'b0, ax_r} + {1'b0, sq_res});
            d_nxt = AW'({1'b0, ax_r} + {1'b0, sq_res}) << 3;
            rr_nxt = times400(ax_r);
            k_nxt = 4'd1; t_nxt = '0;
            state_nxt = S_TEN;
          end
        end
      end
      S_TEN: begin
        t_nxt = t_fin; acc_nxt = acc_r + d_r; d_nxt = d_r + (s_ext << 3);
        k_nxt = k_r + 4'd1;
        if (k_r == act_pkg::TENTH_STEPS) begin
          if (!sel_y_r) begin
            ldx_nxt = dir; sel_y_nxt = 1'b1;
            acc_nxt = s_ext; d_nxt = s_ext << 3; rr_nxt = times400(ay_r);
            k_nxt = 4'd1; t_nxt = '0;
          end else begin
            ldy_nxt = dir; sel_y_nxt = 1'b0;
            state_nxt = S_HIT;
          end
        end
      end
      S_HIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1; out_kind_nxt = act_pkg::KIND_HIT; out_last_nxt = 1'b0;
          out_data_nxt = {2'b00, ldy_r, ldx_r, lsolid_r, 1'b1, lid_r, act_pkg::ST_OK};
          idx_nxt = idx_r + CNTW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SUM: begin
        if (can_load) begin
          out_valid_nxt = 1'b1; out_kind_nxt = act_pkg::KIND_SUMMARY; out_last_nxt = 1'b1;
          out_data_nxt = {2'b00, ldy_r, ldx_r, lsolid_r, hit_r, lid_r, act_pkg::ST_OK};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_r[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt;       op_r <= op_nxt;         status_r <= status_nxt;
    q_r <= q_nxt;           hit_r <= hit_nxt;       lsolid_r <= lsolid_nxt;
    lid_r <= lid_nxt;       ldx_r <= ldx_nxt;       ldy_r <= ldy_nxt;
    vx_r <= vx_nxt;         vy_r <= vy_nxt;         mcand_r <= mcand_nxt;
    prod_r <= prod_nxt;     mplier_r <= mplier_nxt; mcnt_r <= mcnt_nxt;
    ax_r <= ax_nxt;         ay_r <= ay_nxt;         s_r <= s_nxt;
    sel_y_r <= sel_y_nxt;   acc_r <= acc_nxt;       d_r <= d_nxt;
    rr_r <= rr_nxt;         k_r <= k_nxt;           t_r <= t_nxt;
    out_kind_r <= out_kind_nxt; out_data_r <= out_data_nxt; out_last_r <= out_last_nxt;
  end

  `ACT_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNTW'(TABLE_DEPTH), "entry count above depth")
  `ACT_ASSERT_IMPL(a_cnt_step, cnt_r != $past(cnt_r), cnt_r == $past(cnt_r) + CNTW'(1) || cnt_r == $past(cnt_r) - CNTW'(1), "entry count jumped")
  `ACT_ASSERT_IMPL(a_hit_not_last, out_valid_r && out_kind_r == act_pkg::KIND_HIT, !out_last_r, "hit item marked last")
  `ACT_ASSERT_IMPL(a_dir_range, out_valid_r && out_kind_r == act_pkg::KIND_HIT, $signed(out_data_r[24:20]) >= -5'sd10 && $signed(out_data_r[24:20]) <= 5'sd10 && $signed(out_data_r[29:25]) >= -5'sd10 && $signed(out_data_r[29:25]) <= 5'sd10, "direction out of range")

endmodule
